>>> hdl/flv_tag_deframer_assert.svh
// Assertion macros used by the checker file of the FLV tag deframer.
`ifndef FLV_TAG_DEFRAMER_ASSERT_SVH
`define FLV_TAG_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FDF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/fdf_pkg.sv
// Package with the constants, codes and queue record of the FLV tag deframer.
`default_nettype none
package fdf_pkg;

  localparam int unsigned FILE_HDR_BYTES = 13;
  localparam int unsigned TAG_HDR_BYTES  = 11;
  localparam int unsigned TRAILER_BYTES  = 4;

  localparam logic [7:0] ROLL_TOP    = 8'hff;
  localparam logic [7:0] TYPE_AUDIO  = 8'd8;
  localparam logic [7:0] TYPE_VIDEO  = 8'd9;
  localparam logic [7:0] TYPE_SCRIPT = 8'd18;

  localparam logic [23:0] MAX_LEN_RESET = 24'(1024 * 1024);
  localparam logic [23:0] COFS_MIN_LEN  = 24'd5;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DESC    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // One result item as the front hands it to the back.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tag_type;
    logic [7:0]  payload_byte;
    logic        last_of_tag;
    logic [23:0] tag_length;
    logic [47:0] decode_time;
    logic [23:0] cofs;
    logic        add_cofs;
  } rec_t;

endpackage
`default_nettype wire

>>> hdl/fdf_front.sv
// Front of the deframer: accepts stream bytes, tracks tag structure, builds result records.
`default_nettype none
module fdf_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [23:0]   cfg_wdata,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    data_byte,
  input  wire logic          q_full,
  output logic               push,
  output fdf_pkg::rec_t      push_rec
);
  import fdf_pkg::*;

  typedef enum logic [1:0] {
    PH_FILEHDR,
    PH_TAGHDR,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_t;

  localparam logic [3:0] HB_TYPE     = 4'd0;
  localparam logic [3:0] HB_LEN_LAST = 4'd3;
  localparam logic [3:0] HB_TS_LAST  = 4'd6;
  localparam logic [3:0] HB_TS_EXT   = 4'd7;
  localparam logic [3:0] HB_LAST     = 4'(TAG_HDR_BYTES - 1);

  localparam logic [1:0] CLS_AUDIO = 2'd0;
  localparam logic [1:0] CLS_VIDEO = 2'd1;
  localparam logic [1:0] CLS_OTHER = 2'd2;

  function automatic logic [1:0] class_of(input logic [7:0] t);
    logic [1:0] c;
    if (t == TYPE_AUDIO)      c = CLS_AUDIO;
    else if (t == TYPE_VIDEO) c = CLS_VIDEO;
    else                      c = CLS_OTHER;
    return c;
  endfunction

  phase_t      phase, phase_next;
  logic [23:0] cnt, cnt_next;
  logic [7:0]  cur_type, cur_type_next;
  logic [23:0] cur_len, cur_len_next;
  logic [31:0] ts, ts_next;
  logic [23:0] cofs, cofs_next;
  logic [31:0] last_ts [3];
  logic [31:0] last_ts_next [3];
  logic [15:0] roll [3];
  logic [15:0] roll_next [3];
  logic        error_stop, error_stop_next;
  logic [23:0] max_len;

  logic        accept;
  logic [1:0]  cls;
  logic [3:0]  hidx;
  logic [31:0] ts_full;
  logic [23:0] len_shift;
  logic        pay_last;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cls      = class_of(cur_type);
  assign hidx     = cnt[3:0];
  assign ts_full  = {data_byte, ts[23:0]};
  assign len_shift = {cur_len[15:0], data_byte};
  assign pay_last = (({1'b0, cnt} + 25'd1) >= {1'b0, cur_len});

  always_comb begin
    phase_next      = phase;
    cnt_next        = cnt;
    cur_type_next   = cur_type;
    cur_len_next    = cur_len;
    ts_next         = ts;
    cofs_next       = cofs;
    last_ts_next    = last_ts;
    roll_next       = roll;
    error_stop_next = error_stop;

    push                  = 1'b0;
    push_rec.kind         = KIND_PAYLOAD;
    push_rec.tag_type     = cur_type;
    push_rec.payload_byte = 8'd0;
    push_rec.last_of_tag  = 1'b0;
    push_rec.tag_length   = cur_len;
    push_rec.decode_time  = 48'd0;
    push_rec.cofs         = cofs;
    push_rec.add_cofs     = 1'b0;

    if (accept && !error_stop) begin
      unique case (phase)
        PH_FILEHDR: begin
          cnt_next = cnt + 24'd1;
          if (cnt == 24'(FILE_HDR_BYTES - 1)) begin
            cnt_next   = 24'd0;
            phase_next = PH_TAGHDR;
          end
        end
        PH_TAGHDR: begin
          cnt_next = cnt + 24'd1;
          if (hidx == HB_TYPE) begin
            cur_type_next = data_byte;
            cur_len_next  = 24'd0;
            ts_next       = 32'd0;
            cofs_next     = 24'd0;
          end else if (hidx <= HB_LEN_LAST) begin
            cur_len_next = len_shift;
            if (hidx == HB_LEN_LAST && len_shift >= max_len) begin
              error_stop_next     = 1'b1;
              push                = 1'b1;
              push_rec.kind       = KIND_ERROR;
              push_rec.tag_length = len_shift;
              push_rec.cofs       = 24'd0;
            end
          end else if (hidx <= HB_TS_LAST) begin
            ts_next = {8'd0, ts[15:0], data_byte};
          end else if (hidx == HB_TS_EXT) begin
            ts_next = ts_full;
            if (ts_full < last_ts[cls] && last_ts[cls][31:24] == ROLL_TOP) begin
              roll_next[cls] = roll[cls] + 16'd1;
            end
            last_ts_next[cls] = ts_full;
          end
          if (hidx == HB_LAST) begin
            cnt_next   = 24'd0;
            phase_next = (cur_len == 24'd0) ? PH_TRAILER : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (cur_type == TYPE_VIDEO && cnt >= 24'd2 && cnt <= 24'd4) begin
            cofs_next = {cofs[15:0], data_byte};
          end
          cnt_next = cnt + 24'd1;
          if (pay_last) begin
            cnt_next   = 24'd0;
            phase_next = PH_TRAILER;
          end
          if (cur_type == TYPE_AUDIO || cur_type == TYPE_VIDEO ||
              cur_type == TYPE_SCRIPT) begin
            push                  = 1'b1;
            push_rec.payload_byte = data_byte;
            push_rec.last_of_tag  = pay_last;
          end
        end
        PH_TRAILER: begin
          cnt_next = cnt + 24'd1;
          if (cnt == 24'(TRAILER_BYTES - 1)) begin
            cnt_next             = 24'd0;
            phase_next           = PH_TAGHDR;
            push                 = 1'b1;
            push_rec.kind        = KIND_DESC;
            push_rec.decode_time = {roll[cls], last_ts[cls]};
            push_rec.add_cofs    = (cur_type == TYPE_VIDEO) && (cur_len >= COFS_MIN_LEN);
          end
        end
        default: begin
          phase_next = PH_FILEHDR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FILEHDR;
      cnt        <= 24'd0;
      cur_type   <= 8'd0;
      cur_len    <= 24'd0;
      ts         <= 32'd0;
      cofs       <= 24'd0;
      error_stop <= 1'b0;
      max_len    <= MAX_LEN_RESET;
      for (int k = 0; k < 3; k++) begin
        last_ts[k] <= 32'd0;
        roll[k]    <= 16'd0;
      end
    end else begin
      phase      <= phase_next;
      cnt        <= cnt_next;
      cur_type   <= cur_type_next;
      cur_len    <= cur_len_next;
      ts         <= ts_next;
      cofs       <= cofs_next;
      error_stop <= error_stop_next;
      last_ts    <= last_ts_next;
      roll       <= roll_next;
      if (cfg_we) begin
        max_len <= cfg_wdata;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/fdf_queue.sv
// Short register queue that carries result records from the front to the back.
`default_nettype none
module fdf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire fdf_pkg::rec_t push_rec,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output fdf_pkg::rec_t      head_rec
);
  import fdf_pkg::*;

  rec_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_rec   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/fdf_back.sv
// Back of the deframer: adds the composition offset and holds the output register.
`default_nettype none
module fdf_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire fdf_pkg::rec_t q_rec,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         tag_type,
  output logic [7:0]         payload_byte,
  output logic               last_of_tag,
  output logic [23:0]        tag_length,
  output logic [47:0]        decode_time,
  output logic [47:0]        present_time
);
  import fdf_pkg::*;

  logic [47:0] pts;

  assign pop = q_valid && (!out_valid || out_ready);
  assign pts = q_rec.add_cofs ? (q_rec.decode_time + {24'd0, q_rec.cofs})
                              : q_rec.decode_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind     <= q_rec.kind;
      tag_type     <= q_rec.tag_type;
      payload_byte <= q_rec.payload_byte;
      last_of_tag  <= q_rec.last_of_tag;
      tag_length   <= q_rec.tag_length;
      decode_time  <= q_rec.decode_time;
      present_time <= pts;
    end
  end

endmodule
`default_nettype wire

>>> hdl/flv_tag_deframer.sv
// Top level of the FLV tag deframer: front parser, record queue and output back end.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------------
//   input    | in_valid / in_ready    | data_byte
//   output   | out_valid / out_ready  | out_kind, tag_type, payload_byte, last_of_tag,
//            |                        | tag_length, decode_time, present_time
//   config   | cfg_we                 | cfg_wdata (max_tag_length)
//
// The block takes one byte every clock cycle while in_ready is high; a result passes through
// the queue and then the output register, at one item per cycle while out_ready is high.
// The sustained rate is set by the front parser: one byte a cycle while in_ready is high.
// Reset is synchronous; there is no clearing pass.
// A four-entry queue sits between front and back; in_ready falls only when it is full,
// so a stalled output side holds back up to four results plus the output register.
`default_nettype none
module flv_tag_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       tag_type,
  output logic [7:0]       payload_byte,
  output logic             last_of_tag,
  output logic [23:0]      tag_length,
  output logic [47:0]      decode_time,
  output logic [47:0]      present_time
);
  import fdf_pkg::*;

  // Records move from the parser into the queue on the edge that accepts the byte.
  logic q_full;
  logic push;
  rec_t push_rec;

  // Head of the queue as seen by the back end.
  logic q_valid;
  logic pop;
  rec_t q_rec;

  // The front tracks file header, tag header, payload and trailer, keeps the
  // per-class timestamp and rollover state, and owns the length limit register.
  fdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .q_full    (q_full),
    .push      (push),
    .push_rec  (push_rec)
  );

  fdf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_rec   (q_rec)
  );

  // The back end forms the presentation time with one 48-bit add and drives
  // the output register, which refills in the same cycle that it is taken.
  fdf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_rec        (q_rec),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .tag_type     (tag_type),
    .payload_byte (payload_byte),
    .last_of_tag  (last_of_tag),
    .tag_length   (tag_length),
    .decode_time  (decode_time),
    .present_time (present_time)
  );

endmodule
`default_nettype wire

>>> hdl/fdf_checker.sv
// Port-level checker for the FLV tag deframer, bound to the top level.
`default_nettype none
`include "flv_tag_deframer_assert.svh"
module fdf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [7:0]  tag_type,
  input wire logic [7:0]  payload_byte,
  input wire logic        last_of_tag,
  input wire logic [23:0] tag_length,
  input wire logic [47:0] decode_time,
  input wire logic [47:0] present_time
);
  import fdf_pkg::*;

  logic [138:0] out_bus;
  logic         out_take;
  logic         pay_shown;
  logic         times_zero;

  assign out_bus    = {out_kind, tag_type, payload_byte, last_of_tag, tag_length,
                       decode_time, present_time};
  assign out_take   = out_valid && out_ready;
  assign pay_shown  = out_valid && (out_kind == KIND_PAYLOAD);
  assign times_zero = (decode_time == 48'd0) && (present_time == 48'd0);

  // A stalled result holds every field.
  `FDF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_bus))

  // Nothing follows the frame too large error until reset.
  `FDF_ASSERT_NEXT(a_err_final, clk, rst, out_take && out_kind == KIND_ERROR, !out_valid)

  // Payload items carry no times.
  `FDF_ASSERT_NOW(a_pay_no_time, clk, rst, pay_shown, times_zero)

  // Only payload items carry a byte or a last marker.
  `FDF_ASSERT_NOW(a_nonpay_clean, clk, rst, out_valid && !pay_shown, !last_of_tag && payload_byte == '0)

endmodule

bind flv_tag_deframer fdf_checker u_fdf_checker (.*);
`default_nettype wire
